>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL; compiled out by ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> rtl/core/i2cms_pkg.sv
// ---------------------------------------------------------------------------
// i2cms_pkg
// Shared types, codes and defaults of the I2C master transfer sequencer.
// ---------------------------------------------------------------------------
package i2cms_pkg;

    localparam int DEF_COUNT_WIDTH       = 16;
    localparam int DEF_MAX_ADDRESS_BYTES = 4;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 32;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_SLAVE_ADDRESS  = 2'd0;
    localparam logic [1:0] REG_ADDRESS_LENGTH = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS  = 2'd2;

    localparam logic [7:0] RST_SLAVE_ADDRESS  = 8'd0;
    localparam logic [2:0] RST_ADDRESS_LENGTH = 3'd1;
    localparam logic [7:0] RST_TIMEOUT_TICKS  = 8'd100;

    // Item opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_EVENT = 2'd1;
    localparam logic [1:0] OP_ERROR = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // Controller event codes
    localparam logic [2:0] EV_MODE_SELECT = 3'd0;
    localparam logic [2:0] EV_TX_SELECTED = 3'd1;
    localparam logic [2:0] EV_TX_BYTE     = 3'd2;
    localparam logic [2:0] EV_TX_DONE     = 3'd3;
    localparam logic [2:0] EV_RX_SELECTED = 3'd4;
    localparam logic [2:0] EV_RX_BYTE     = 3'd5;

    // Transfer status
    localparam logic [1:0] ST_READY = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_HUNG  = 2'd2;

    // Buffer interrupt control
    localparam logic [1:0] BUF_IRQ_KEEP    = 2'd0;
    localparam logic [1:0] BUF_IRQ_ENABLE  = 2'd1;
    localparam logic [1:0] BUF_IRQ_DISABLE = 2'd2;

    typedef struct packed {
        logic [7:0] slave_address;
        logic [2:0] address_length;
        logic [7:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        is_read;
        logic [31:0] mem_address;
        logic [15:0] byte_count;
        logic [2:0]  event_code;
        logic [7:0]  rx_byte;
        logic [7:0]  tx_byte;
    } t_in_item;

    typedef struct packed {
        logic       dr_write_valid;
        logic [7:0] dr_value;
        logic       gen_start;
        logic       gen_stop;
        logic       ack_disable;
        logic [1:0] buf_irq_ctrl;
        logic       irq_disable;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       tx_consumed;
        logic [1:0] status;
        logic       done_res;
    } t_result;

endpackage

>>> rtl/core/i2cms_apb_regs.sv
// ---------------------------------------------------------------------------
// i2cms_apb_regs
// APB configuration registers: slave address, address length, timeout.
// ---------------------------------------------------------------------------
module i2cms_apb_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [i2cms_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [i2cms_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [i2cms_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready,
    output i2cms_pkg::t_cfg                    o_cfg
);
    import i2cms_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_address  <= RST_SLAVE_ADDRESS;
            r_cfg.address_length <= RST_ADDRESS_LENGTH;
            r_cfg.timeout_ticks  <= RST_TIMEOUT_TICKS;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SLAVE_ADDRESS:  r_cfg.slave_address  <= pwdata[7:0];
                REG_ADDRESS_LENGTH: r_cfg.address_length <= pwdata[2:0];
                REG_TIMEOUT_TICKS:  r_cfg.timeout_ticks  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SLAVE_ADDRESS:  prdata = {24'd0, r_cfg.slave_address};
            REG_ADDRESS_LENGTH: prdata = {29'd0, r_cfg.address_length};
            REG_TIMEOUT_TICKS:  prdata = {24'd0, r_cfg.timeout_ticks};
            default:            prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/i2cms_seq_core.sv
// ---------------------------------------------------------------------------
// i2cms_seq_core
// Transfer state registers and the per-item decision logic.
// ---------------------------------------------------------------------------
module i2cms_seq_core #(
    parameter int COUNT_WIDTH       = i2cms_pkg::DEF_COUNT_WIDTH,
    parameter int MAX_ADDRESS_BYTES = i2cms_pkg::DEF_MAX_ADDRESS_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  i2cms_pkg::t_in_item  i_item,
    input  i2cms_pkg::t_cfg      i_cfg,
    output i2cms_pkg::t_result   o_result
);
    import i2cms_pkg::*;

    localparam logic [2:0] MaxAb = 3'(MAX_ADDRESS_BYTES);

    logic [1:0]             r_status,     n_status;
    logic                   r_read_mode,  n_read_mode;
    logic [2:0]             r_abl,        n_abl;
    logic [31:0]            r_addr_shd,   n_addr_shd;
    logic [COUNT_WIDTH-1:0] r_bytes_left, n_bytes_left;
    logic [7:0]             r_timeout,    n_timeout;

    logic [COUNT_WIDTH-1:0] bl_dec;
    logic [7:0]             to_dec;
    logic [1:0]             ab_idx;
    logic [2:0]             al_sat;
    logic                   busy;
    t_result                res;

    assign bl_dec = r_bytes_left - COUNT_WIDTH'(1);
    assign to_dec = r_timeout - 8'd1;
    assign ab_idx = r_abl[1:0] - 2'd1;
    assign al_sat = (i_cfg.address_length > MaxAb) ? MaxAb : i_cfg.address_length;
    assign busy   = (r_status == ST_BUSY);

    always_comb begin
        n_status     = r_status;
        n_read_mode  = r_read_mode;
        n_abl        = r_abl;
        n_addr_shd   = r_addr_shd;
        n_bytes_left = r_bytes_left;
        n_timeout    = r_timeout;
        res          = '0;

        case (i_item.opcode)
            OP_START: begin
                if (!busy) begin
                    n_status     = ST_BUSY;
                    n_read_mode  = i_item.is_read;
                    n_abl        = al_sat;
                    n_addr_shd   = i_item.mem_address;
                    n_bytes_left = COUNT_WIDTH'(i_item.byte_count);
                    n_timeout    = i_cfg.timeout_ticks;
                    res.gen_start = 1'b1;
                end
            end
            OP_EVENT: begin
                if (busy) begin
                    case (i_item.event_code)
                        EV_MODE_SELECT: begin
                            res.dr_write_valid = 1'b1;
                            if (!r_read_mode || r_abl != 3'd0) begin
                                res.dr_value = {i_cfg.slave_address[7:1], 1'b0};
                            end else begin
                                res.dr_value = {i_cfg.slave_address[7:1], 1'b1};
                            end
                        end
                        EV_TX_SELECTED, EV_TX_BYTE: begin
                            if (i_item.event_code == EV_TX_SELECTED) begin
                                res.buf_irq_ctrl = BUF_IRQ_ENABLE;
                            end
                            // address bytes first, MSB first, then write data
                            if (r_abl != 3'd0) begin
                                res.dr_write_valid = 1'b1;
                                res.dr_value       = r_addr_shd[8*ab_idx +: 8];
                                n_abl              = r_abl - 3'd1;
                            end else if (r_read_mode) begin
                                res.buf_irq_ctrl = BUF_IRQ_DISABLE;
                            end else if (r_bytes_left != '0) begin
                                res.dr_write_valid = 1'b1;
                                res.dr_value       = i_item.tx_byte;
                                res.tx_consumed    = 1'b1;
                                n_bytes_left       = bl_dec;
                            end else begin
                                res.buf_irq_ctrl = BUF_IRQ_DISABLE;
                            end
                        end
                        EV_TX_DONE: begin
                            if (r_read_mode) begin
                                res.gen_start = 1'b1;
                            end else begin
                                res.gen_stop    = 1'b1;
                                res.irq_disable = 1'b1;
                                res.done_res    = 1'b1;
                                n_status        = ST_READY;
                                n_timeout       = 8'd0;
                            end
                        end
                        EV_RX_SELECTED: begin
                            if (r_bytes_left == COUNT_WIDTH'(1)) begin
                                res.ack_disable = 1'b1;
                                res.gen_stop    = 1'b1;
                            end
                            res.buf_irq_ctrl = BUF_IRQ_ENABLE;
                        end
                        EV_RX_BYTE: begin
                            if (r_bytes_left != '0) begin
                                res.rx_valid = 1'b1;
                                res.rx_data  = i_item.rx_byte;
                                n_bytes_left = bl_dec;
                                if (bl_dec == COUNT_WIDTH'(1)) begin
                                    res.ack_disable = 1'b1;
                                    res.gen_stop    = 1'b1;
                                end else if (bl_dec == '0) begin
                                    res.irq_disable = 1'b1;
                                    res.done_res    = 1'b1;
                                    n_status        = ST_READY;
                                    n_timeout       = 8'd0;
                                end
                            end else begin
                                // zero-length read: end without storing
                                res.irq_disable = 1'b1;
                                res.done_res    = 1'b1;
                                n_status        = ST_READY;
                                n_timeout       = 8'd0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_ERROR: begin
                res.done_res = busy;
                n_status     = ST_READY;
                n_timeout    = 8'd0;
            end
            default: begin
                if (r_timeout != 8'd0) begin
                    n_timeout = to_dec;
                    if (to_dec == 8'd0) begin
                        res.done_res = busy;
                        n_status     = ST_HUNG;
                    end
                end
            end
        endcase

        res.status = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status     <= ST_READY;
            r_read_mode  <= 1'b0;
            r_abl        <= 3'd0;
            r_addr_shd   <= '0;
            r_bytes_left <= '0;
            r_timeout    <= 8'd0;
        end else if (i_accept) begin
            r_status     <= n_status;
            r_read_mode  <= n_read_mode;
            r_abl        <= n_abl;
            r_addr_shd   <= n_addr_shd;
            r_bytes_left <= n_bytes_left;
            r_timeout    <= n_timeout;
        end
    end

    assign o_result = res;

endmodule

>>> rtl/core/i2cms_out_buf.sv
// ---------------------------------------------------------------------------
// i2cms_out_buf
// Result register with one skid entry between the core and the output port.
// ---------------------------------------------------------------------------
module i2cms_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  i2cms_pkg::t_result  i_result,
    output logic                o_valid,
    input  logic                i_ready,
    output i2cms_pkg::t_result  o_result
);
    import i2cms_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    take;
    logic    load;

    assign o_ready = !r_skid_valid;
    assign take    = r_out_valid & i_ready;
    assign load    = i_valid & o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (load) begin
            if (r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (load) begin
            if (r_out_valid && !take) begin
                r_skid <= i_result;
            end else begin
                r_out <= i_result;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

>>> rtl/core/i2c_master_transfer_sequencer_top.sv
// One item is taken per clock while o_s_axis_tready is high. Its result is
// registered; every item, whether a start request, a controller event,
// an error or a timeout tick, gives exactly one result. The transfer state
// is updated in the same cycle the item is accepted, so items may follow
// back to back. Results pass through a result register and one skid entry:
// o_s_axis_tready falls only when both hold a result the sink has not
// taken. Configuration is read as items are taken (the start request and
// the mode-select event), so write it only while no item is in flight.
// ---------------------------------------------------------------------------
// i2c_master_transfer_sequencer_top
// I2C master register-addressed transfer sequencer with APB configuration.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_master_transfer_sequencer_top #(
    parameter int COUNT_WIDTH       = i2cms_pkg::DEF_COUNT_WIDTH,
    parameter int MAX_ADDRESS_BYTES = i2cms_pkg::DEF_MAX_ADDRESS_BYTES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // is_read, mem_address[31:0], byte_count[15:0], event_code[2:0],
    // rx_byte[7:0], tx_byte[7:0], zero pad
    input  logic [i2cms_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]                          i_s_axis_tuser,
    // master stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // dr_write_valid, dr_value[7:0], gen_start, gen_stop, ack_disable,
    // buf_irq_ctrl[1:0], irq_disable, rx_valid, rx_data[7:0], tx_consumed,
    // status[1:0], zero pad
    output logic [i2cms_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // done_res
    output logic                                o_m_axis_tlast,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [i2cms_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [i2cms_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [i2cms_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import i2cms_pkg::*;

    t_cfg     cfg;
    t_in_item item;
    t_result  core_res;
    t_result  out_res;
    logic     accept;

    assign item.opcode      = i_s_axis_tuser;
    assign item.is_read     = i_s_axis_tdata[0];
    assign item.mem_address = i_s_axis_tdata[32:1];
    assign item.byte_count  = i_s_axis_tdata[48:33];
    assign item.event_code  = i_s_axis_tdata[51:49];
    assign item.rx_byte     = i_s_axis_tdata[59:52];
    assign item.tx_byte     = i_s_axis_tdata[67:60];

    assign accept = i_s_axis_tvalid & o_s_axis_tready;

    i2cms_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    i2cms_seq_core #(
        .COUNT_WIDTH       (COUNT_WIDTH),
        .MAX_ADDRESS_BYTES (MAX_ADDRESS_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .i_cfg    (cfg),
        .o_result (core_res)
    );

    i2cms_out_buf u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_result (core_res),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (out_res)
    );

    assign o_m_axis_tdata = {5'd0,
                             out_res.status,
                             out_res.tx_consumed,
                             out_res.rx_data,
                             out_res.rx_valid,
                             out_res.irq_disable,
                             out_res.buf_irq_ctrl,
                             out_res.ack_disable,
                             out_res.gen_stop,
                             out_res.gen_start,
                             out_res.dr_value,
                             out_res.dr_write_valid};
    assign o_m_axis_tlast = out_res.done_res;

    // stall only with a full output stage
    `ASSERT_NEVER(a_stall_needs_full, i_clk, i_rst_n, !o_s_axis_tready && !o_m_axis_tvalid, "input stalled with output empty")
    // a finishing item never leaves the transfer busy
    `ASSERT_NEVER(a_done_not_busy, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tlast && (o_m_axis_tdata[26:25] == ST_BUSY), "done result reports busy")
    // data fields stay zero unless flagged
    `ASSERT_NEVER(a_dr_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tdata[0] && (o_m_axis_tdata[8:1] != 8'd0), "dr_value set without dr_write_valid")
    `ASSERT_NEVER(a_rx_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tdata[15] && (o_m_axis_tdata[23:16] != 8'd0), "rx_data set without rx_valid")

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C master transfer sequencer. Items go in on
// the slave stream under random idling; a behavioral copy of the sequencer
// computes each output word, and every word on the master stream is checked
// in order against it. Directed tests cover write and read transfers and the
// corner cases; random phases sweep the registers and run transfer scripts
// mixed with timeout ticks, aborts and noise items.
// ---------------------------------------------------------------------------
module tb_top;
    import i2cms_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_ITEMS   = 1850;
    localparam int DRAIN_CYCLES   = 10;
    localparam logic [2:0] MAX_ADDR_BYTES = 3'(DEF_MAX_ADDRESS_BYTES);

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic [1:0]             i_s_axis_tuser = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    i2c_master_transfer_sequencer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // register copies
    logic [7:0]  cfg_slave    = RST_SLAVE_ADDRESS;
    logic [2:0]  cfg_addr_len = RST_ADDRESS_LENGTH;
    logic [7:0]  cfg_timeout  = RST_TIMEOUT_TICKS;

    // transfer state
    logic [1:0]  xfer_status = ST_READY;
    logic        xfer_read   = 1'b0;
    logic [2:0]  addr_left   = '0;
    logic [31:0] addr_shadow = '0;
    logic [15:0] data_left   = '0;
    logic [7:0]  tick_count  = '0;

    t_result     outputs_due[$];
    int          error_count = 0;
    int          items_sent  = 0;
    int          cycle_count = 0;
    bit          gaps_on     = 1'b0;
    bit          noise_on    = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic void end_transfer(inout t_result r);
        r.irq_disable = 1'b1;
        r.done_res    = 1'b1;
        xfer_status   = ST_READY;
        tick_count    = '0;
    endfunction

    // Advance the transfer state by one item and return the output word it gives.
    function automatic t_result sequencer_step(input t_in_item it);
        t_result r;
        r = '0;
        case (it.opcode)
            OP_START: begin
                if (xfer_status != ST_BUSY) begin
                    xfer_status = ST_BUSY;
                    xfer_read   = it.is_read;
                    addr_left   = (cfg_addr_len > MAX_ADDR_BYTES) ? MAX_ADDR_BYTES : cfg_addr_len;
                    addr_shadow = it.mem_address;
                    data_left   = it.byte_count;
                    tick_count  = cfg_timeout;
                    r.gen_start = 1'b1;
                end
            end
            OP_EVENT: begin
                if (xfer_status == ST_BUSY) begin
                    case (it.event_code)
                        EV_MODE_SELECT: begin
                            r.dr_write_valid = 1'b1;
                            r.dr_value = {cfg_slave[7:1], xfer_read && addr_left == 0};
                        end
                        EV_TX_SELECTED, EV_TX_BYTE: begin
                            if (it.event_code == EV_TX_SELECTED)
                                r.buf_irq_ctrl = BUF_IRQ_ENABLE;
                            if (addr_left != 0) begin
                                r.dr_write_valid = 1'b1;
                                r.dr_value = 8'(addr_shadow >> (8 * (addr_left - 1)));
                                addr_left = addr_left - 3'd1;
                            end else if (!xfer_read && data_left != 0) begin
                                r.dr_write_valid = 1'b1;
                                r.dr_value       = it.tx_byte;
                                r.tx_consumed    = 1'b1;
                                data_left        = data_left - 16'd1;
                            end else begin
                                r.buf_irq_ctrl = BUF_IRQ_DISABLE;
                            end
                        end
                        EV_TX_DONE: begin
                            if (xfer_read) begin
                                r.gen_start = 1'b1;
                            end else begin
                                r.gen_stop = 1'b1;
                                end_transfer(r);
                            end
                        end
                        EV_RX_SELECTED: begin
                            if (data_left == 1) begin
                                r.ack_disable = 1'b1;
                                r.gen_stop    = 1'b1;
                            end
                            r.buf_irq_ctrl = BUF_IRQ_ENABLE;
                        end
                        EV_RX_BYTE: begin
                            if (data_left != 0) begin
                                r.rx_valid = 1'b1;
                                r.rx_data  = it.rx_byte;
                                data_left  = data_left - 16'd1;
                                if (data_left == 1) begin
                                    r.ack_disable = 1'b1;
                                    r.gen_stop    = 1'b1;
                                end else if (data_left == 0) begin
                                    end_transfer(r);
                                end
                            end else begin
                                end_transfer(r);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_ERROR: begin
                r.done_res  = (xfer_status == ST_BUSY);
                xfer_status = ST_READY;
                tick_count  = '0;
            end
            default: begin
                if (tick_count != 0) begin
                    tick_count = tick_count - 8'd1;
                    if (tick_count == 0) begin
                        r.done_res  = (xfer_status == ST_BUSY);
                        xfer_status = ST_HUNG;
                    end
                end
            end
        endcase
        r.status = xfer_status;
        return r;
    endfunction

    function automatic string fmt_result(input t_result r);
        return $sformatf({"dr %0b/%02h start %0b stop %0b nack %0b buf %0d irq %0b ",
                          "rx %0b/%02h txc %0b st %0d done %0b"},
                         r.dr_write_valid, r.dr_value, r.gen_start, r.gen_stop,
                         r.ack_disable, r.buf_irq_ctrl, r.irq_disable, r.rx_valid,
                         r.rx_data, r.tx_consumed, r.status, r.done_res);
    endfunction

    function automatic void note_mismatch(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endfunction

    // Sink: stall at random and check each output word against the oldest one due.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        i_m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= 10);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.dr_write_valid = o_m_axis_tdata[0];
            got.dr_value       = o_m_axis_tdata[8:1];
            got.gen_start      = o_m_axis_tdata[9];
            got.gen_stop       = o_m_axis_tdata[10];
            got.ack_disable    = o_m_axis_tdata[11];
            got.buf_irq_ctrl   = o_m_axis_tdata[13:12];
            got.irq_disable    = o_m_axis_tdata[14];
            got.rx_valid       = o_m_axis_tdata[15];
            got.rx_data        = o_m_axis_tdata[23:16];
            got.tx_consumed    = o_m_axis_tdata[24];
            got.status         = o_m_axis_tdata[26:25];
            got.done_res       = o_m_axis_tlast;
            if (outputs_due.size() == 0) begin
                note_mismatch({"unexpected output ", fmt_result(got)});
            end else begin
                want = outputs_due.pop_front();
                if (got !== want)
                    note_mismatch({"expected ", fmt_result(want), " got ", fmt_result(got)});
            end
        end
    end

    function automatic t_in_item random_item();
        t_in_item it;
        it.opcode      = 2'($urandom);
        it.is_read     = 1'($urandom);
        it.mem_address = $urandom;
        it.byte_count  = 16'($urandom);
        it.event_code  = 3'($urandom);
        it.rx_byte     = 8'($urandom);
        it.tx_byte     = 8'($urandom);
        return it;
    endfunction

    function automatic t_in_item make_item(input logic [1:0] op, input logic [2:0] ev);
        t_in_item it;
        it            = random_item();
        it.opcode     = op;
        it.event_code = ev;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        while (gaps_on && $urandom_range(0, 99) < 10) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= it.opcode;
        i_s_axis_tdata  <= {4'b0, it.tx_byte, it.rx_byte, it.event_code, it.byte_count,
                            it.mem_address, it.is_read};
        do @(posedge i_clk); while (!o_s_axis_tready);
        outputs_due.push_back(sequencer_step(it));
        items_sent++;
    endtask

    // Slip a timeout tick or a noise item in ahead of the scripted one.
    task automatic send_in_stream(input t_in_item it);
        if (noise_on && $urandom_range(0, 99) < 10)
            send_item(make_item(OP_TICK, 3'($urandom)));
        if (noise_on && $urandom_range(0, 99) < 4)
            send_item(random_item());
        send_item(it);
    endtask

    task automatic send_event(input logic [2:0] ev);
        send_in_stream(make_item(OP_EVENT, ev));
    endtask

    task automatic send_start(input logic rd, input logic [31:0] addr, input logic [15:0] cnt);
        t_in_item it;
        it             = make_item(OP_START, 3'($urandom));
        it.is_read     = rd;
        it.mem_address = addr;
        it.byte_count  = cnt;
        send_in_stream(it);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (outputs_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_config(input logic [1:0] reg_idx, input logic [7:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            REG_SLAVE_ADDRESS:  cfg_slave    = value;
            REG_ADDRESS_LENGTH: cfg_addr_len = value[2:0];
            default:            cfg_timeout  = value;
        endcase
    endtask

    task automatic test_write_transfer();
        t_in_item it;
        set_config(REG_SLAVE_ADDRESS, 8'hFF);
        set_config(REG_ADDRESS_LENGTH, 8'd2);
        send_start(1'b0, 32'hFFFF_FFFF, 16'd1);
        send_event(EV_MODE_SELECT);
        send_event(EV_TX_SELECTED);
        send_event(EV_TX_BYTE);
        it = make_item(OP_EVENT, EV_TX_BYTE);
        it.tx_byte = 8'hFF;
        send_item(it);
        send_event(EV_TX_BYTE);
        send_event(EV_TX_DONE);
    endtask

    task automatic test_read_transfer();
        t_in_item it;
        set_config(REG_SLAVE_ADDRESS, 8'h00);
        set_config(REG_ADDRESS_LENGTH, 8'd0);
        send_start(1'b1, 32'h0000_0000, 16'd2);
        send_event(EV_MODE_SELECT);
        send_event(EV_TX_SELECTED);     // enable then disable in one item
        send_event(EV_TX_DONE);
        send_event(EV_RX_SELECTED);
        it = make_item(OP_EVENT, EV_RX_BYTE);
        it.rx_byte = 8'h00;
        send_item(it);
        it.rx_byte = 8'hFF;
        send_item(it);
    endtask

    task automatic test_corner_cases();
        send_start(1'b1, $urandom, 16'd0);
        send_start(1'b0, $urandom, 16'd5);  // ignored while busy
        send_event(3'd6);
        send_event(3'd7);
        send_event(EV_RX_BYTE);             // zero-byte read ends here
        send_event(EV_TX_SELECTED);         // ignored while ready
        send_item(make_item(OP_ERROR, 3'($urandom)));
        send_start(1'b0, 32'h0, 16'hFFFF);
        send_item(make_item(OP_ERROR, 3'($urandom)));
        set_config(REG_TIMEOUT_TICKS, 8'd1);
        send_start(1'b0, $urandom, 16'd3);
        send_item(make_item(OP_TICK, 3'($urandom)));
        send_item(make_item(OP_TICK, 3'($urandom)));
        send_start(1'b1, $urandom, 16'd3);  // restart out of hung
        send_item(make_item(OP_ERROR, 3'($urandom)));
        set_config(REG_TIMEOUT_TICKS, 8'd0);
        send_start(1'b0, $urandom, 16'd3);
        send_item(make_item(OP_TICK, 3'($urandom)));
        send_item(make_item(OP_TICK, 3'($urandom)));
        send_item(make_item(OP_ERROR, 3'($urandom)));
    endtask

    // One scripted transfer, either run to its end or cut short by an error item.
    task automatic run_transfer();
        logic        rd;
        int          n;
        int          n_send;
        int          al;
        int          tx_n;
        bit          complete;
        rd = 1'($urandom);
        n  = ($urandom_range(0, 11) == 0) ? int'(16'($urandom)) : $urandom_range(0, 6);
        complete = (n <= 6) && ($urandom_range(0, 9) != 0);
        if (n > 6)
            n_send = $urandom_range(0, 6);
        else
            n_send = complete ? n : $urandom_range(0, n);
        al   = int'((cfg_addr_len > MAX_ADDR_BYTES) ? MAX_ADDR_BYTES : cfg_addr_len);
        tx_n = al + (rd ? 1 : n_send + 1);
        send_start(rd, $urandom, 16'(n));
        send_event(EV_MODE_SELECT);
        for (int i = 0; i < tx_n; i++)
            send_event(i == 0 ? EV_TX_SELECTED : EV_TX_BYTE);
        if (rd) begin
            send_event(EV_TX_DONE);
            send_event(EV_MODE_SELECT);
            send_event(EV_RX_SELECTED);
            repeat ((n_send == 0) ? 1 : n_send)
                send_event(EV_RX_BYTE);
        end else if (complete) begin
            send_event(EV_TX_DONE);
        end
        if (!complete)
            send_in_stream(make_item(OP_ERROR, 3'($urandom)));
    endtask

    task automatic test_random_transfers();
        logic [7:0] len_sweep[8]  = '{8'd1, 8'd0, 8'd4, 8'd7, 8'd2, 8'd5, 8'd3, 8'd6};
        logic [7:0] tick_sweep[8] = '{8'd255, 8'd1, 8'd0, 8'd100, 8'd4, 8'd12, 8'd2, 8'd30};
        int         target;
        noise_on = 1'b1;
        for (int p = 0; p < 8; p++) begin
            set_config(REG_SLAVE_ADDRESS, (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom));
            set_config(REG_ADDRESS_LENGTH, len_sweep[p]);
            set_config(REG_TIMEOUT_TICKS, tick_sweep[p]);
            gaps_on = (p != 3);
            target  = items_sent + RANDOM_ITEMS / 8;
            while (items_sent < target)
                run_transfer();
        end
        noise_on = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gaps_on = 1'b1;
        test_write_transfer();
        test_read_transfer();
        test_corner_cases();
        test_random_transfers();
        gaps_on = 1'b1;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (outputs_due.size() != 0)
            note_mismatch($sformatf("%0d outputs never arrived", outputs_due.size()));
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
